FILE: rtl/vsgm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsgm_pkg
// Request and result types shared by the slice greedy mesher.
// ----------------------------------------------------------------------------
package vsgm_pkg;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_MESH = 1'b1;
    localparam int   MAX_QUADS = 16;
    localparam int   SIDE      = 32;

    typedef struct packed {
        logic        action;
        logic [4:0]  col;
        logic [4:0]  row;
        logic [15:0] cell_tile;
        logic [15:0] facing_tile;
        logic        cell_clear;
        logic        facing_clear;
    } request_t;

    typedef struct packed {
        logic        quad_valid;
        logic [4:0]  quad_col;
        logic [4:0]  quad_row;
        logic [5:0]  quad_width;
        logic [5:0]  quad_height;
        logic [15:0] quad_tile;
        logic        final_res;
    } result_t;

endpackage

FILE: rtl/voxel_slice_greedy_mesher_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voxel_slice_greedy_mesher_core
// Greedy quad mesher for one square voxel slice held in on-chip memory.
// ----------------------------------------------------------------------------
// Usage: drive req and pulse start while busy is low. A load request writes
// one cell (tile, draw bit, same-as-row-below bit); a mesh request emits the
// maximal quads that start in one column, each on res for one cycle marked
// by res_strobe, the last one with final_res set. An empty column gives one
// result with quad_valid low.
// Steps: a load reads the row below, then writes.
// A mesh request runs a quad search (column read, select) before each quad
// and once at the end; each quad then takes a tile read, a mask/tile read and
// compare per column tested for widening, a further step when the slice edge
// is reached, plus an erasure read and write-back per covered column. Each
// quad is strobed in the cycle after the next search; the last result goes
// out through S_EMIT after the final search. The single-port mask and tile
// memories are walked one column a step.
// Reset clears the state machine and sweeps the mask memories to zero,
// one column a cycle, with busy held high. The tile memory
// is not cleared. The receiver cannot stall; results are never held.
// ----------------------------------------------------------------------------
module voxel_slice_greedy_mesher_core #(
    parameter int TILE_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  vsgm_pkg::request_t req,
    output logic               res_strobe,
    output vsgm_pkg::result_t  res
);
    localparam int SIDE = vsgm_pkg::SIDE;
    localparam int CW = (SIDE > 1) ? $clog2(SIDE) : 1;
    localparam int CB = $clog2(SIDE + 1);
    localparam int AW = 2 * CW;
    localparam int QB = $clog2(vsgm_pkg::MAX_QUADS + 1);

    localparam logic [3:0] S_CLR   = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_LRD   = 4'd2;
    localparam logic [3:0] S_LWR   = 4'd3;
    localparam logic [3:0] S_MRD   = 4'd4;
    localparam logic [3:0] S_MSEL  = 4'd5;
    localparam logic [3:0] S_TRD   = 4'd6;
    localparam logic [3:0] S_WRD   = 4'd7;
    localparam logic [3:0] S_WCMP  = 4'd8;
    localparam logic [3:0] S_ERD   = 4'd9;
    localparam logic [3:0] S_EWR   = 4'd10;
    localparam logic [3:0] S_EMIT  = 4'd11;
    localparam logic [3:0] S_EMPTY = 4'd12;

    // mask memory: visible and same words of one column per entry
    logic [2*SIDE-1:0]    mask_mem [SIDE];
    logic [TILE_BITS-1:0] tile_mem [SIDE*SIDE];
    logic [2*SIDE-1:0]    mask_rd;
    logic [TILE_BITS-1:0] tile_rd;

    logic                 m_we, t_we;
    logic [CW-1:0]        m_addr;
    logic [2*SIDE-1:0]    m_wdata;
    logic [AW-1:0]        t_addr;

    logic [3:0]           state_reg, state_next;
    logic [CB-1:0]        cnt_reg, cnt_next;      // sweep / width column
    logic [CW-1:0]        u_reg;
    logic [CW-1:0]        v_reg;
    logic [TILE_BITS-1:0] tile_reg;
    logic                 draw_reg;
    logic [CB-1:0]        sv_reg, h_reg, w_reg;
    logic [TILE_BITS-1:0] qtile_reg;
    logic [SIDE-1:0]      hcut_reg, pcut_reg, ecut_reg;
    logic [QB-1:0]        qcnt_reg;
    logic                 res_strobe_reg;
    vsgm_pkg::result_t    res_reg;

    always_ff @(posedge clk)
    begin
        if (m_we)
            mask_mem[m_addr] <= m_wdata;
        mask_rd <= mask_mem[m_addr];
    end

    always_ff @(posedge clk)
    begin
        if (t_we)
            tile_mem[t_addr] <= tile_reg;
        tile_rd <= tile_mem[t_addr];
    end

    // start column words, valid in S_MSEL
    logic [SIDE-1:0] col_vis, col_same;
    assign col_vis  = mask_rd[SIDE-1:0];
    assign col_same = mask_rd[2*SIDE-1:SIDE];

    // quad search on the start column words (priority scans)
    logic [CB-1:0]   f_sv, f_hv, f_hs, f_h;
    logic            f_any;
    logic [SIDE-1:0] f_hcut, f_pcut, f_ecut;
    always_comb
    begin
        logic            found, vdone, sdone;
        logic [SIDE-1:0] vsh, ssh;
        logic [CB-1:0]   sone;
        logic [CB:0]     ii, lo, hi;
        f_sv = '0;
        found = 1'b0;
        for (int i = 0; i < SIDE; i++)
        begin
            if (!found && col_vis[i])
            begin
                found = 1'b1;
                f_sv = CB'(i);
            end
        end
        f_any = found;
        // run lengths: first clear bit above the start row
        vsh = col_vis >> f_sv;
        ssh = col_same >> (f_sv + CB'(1));
        f_hv = CB'(SIDE);
        sone = CB'(SIDE);
        vdone = 1'b0;
        sdone = 1'b0;
        for (int i = 0; i < SIDE; i++)
        begin
            if (!vdone && !vsh[i])
            begin
                vdone = 1'b1;
                f_hv = CB'(i);
            end
            if (!sdone && !ssh[i])
            begin
                sdone = 1'b1;
                sone = CB'(i);
            end
        end
        f_hs = sone + CB'(1);
        f_h  = (f_hv < f_hs) ? f_hv : f_hs;
        lo = {1'b0, f_sv};
        hi = lo + {1'b0, f_h};
        for (int i = 0; i < SIDE; i++)
        begin
            ii = (CB+1)'(i);
            f_hcut[i] = (ii >= lo) && (ii < hi);
            f_pcut[i] = (ii > lo) && (ii < hi);
            f_ecut[i] = (ii > lo) && (ii <= hi);
        end
    end

    logic [CB:0] next_col;
    assign next_col = {1'b0, CB'(u_reg)} + {1'b0, w_reg};

    logic load_ok;
    assign load_ok = ({1'b0, req.col} < 6'(SIDE)) && ({1'b0, req.row} < 6'(SIDE));

    logic [TILE_BITS-1:0] in_tile, in_face;
    logic in_draw;
    assign in_tile = req.cell_tile[TILE_BITS-1:0];
    assign in_face = req.facing_tile[TILE_BITS-1:0];
    assign in_draw = (in_tile != '0) &&
                     ((!req.cell_clear && !((in_face != '0) && !req.facing_clear)) ||
                      (req.cell_clear && (in_face == '0)));

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        m_we       = 1'b0;
        t_we       = 1'b0;
        m_addr     = u_reg;
        m_wdata    = mask_rd;
        t_addr     = {u_reg, v_reg};
        case (state_reg)
            S_CLR:
            begin
                m_we    = 1'b1;
                m_addr  = cnt_reg[CW-1:0];
                m_wdata = '0;
                cnt_next = cnt_reg + CB'(1);
                if (cnt_reg == CB'(SIDE - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (start)
                begin
                    if (req.action == vsgm_pkg::ACT_LOAD)
                        state_next = load_ok ? S_LRD : S_IDLE;
                    else if ({1'b0, req.col} < 6'(SIDE))
                        state_next = S_MRD;
                    else
                        state_next = S_EMPTY;
                end
            end
            S_LRD:
            begin
                // read the row below and this column's masks
                t_addr = {u_reg, v_reg - CW'(1)};
                state_next = S_LWR;
            end
            S_LWR:
            begin
                m_we = 1'b1;
                t_we = 1'b1;
                m_wdata = mask_rd;
                m_wdata[v_reg] = draw_reg;
                m_wdata[SIDE + 32'(v_reg)] = (v_reg != '0) && (tile_rd == tile_reg);
                state_next = S_IDLE;
            end
            S_MRD:
                state_next = S_MSEL;
            S_MSEL:
            begin
                if (!f_any || qcnt_reg == QB'(vsgm_pkg::MAX_QUADS))
                    state_next = (qcnt_reg == '0) ? S_EMPTY : S_EMIT;
                else
                    state_next = S_TRD;
            end
            S_TRD:
            begin
                t_addr = {u_reg, sv_reg[CW-1:0]};
                state_next = S_WRD;
                cnt_next = CB'(1);
            end
            S_WRD:
            begin
                if (next_col >= (CB+1)'(SIDE))
                begin
                    state_next = S_ERD;
                    cnt_next = '0;
                end
                else
                begin
                    m_addr = next_col[CW-1:0];
                    t_addr = {next_col[CW-1:0], sv_reg[CW-1:0]};
                    state_next = S_WCMP;
                end
            end
            S_WCMP:
            begin
                if (((mask_rd[SIDE-1:0] & hcut_reg) == hcut_reg) &&
                    ((mask_rd[2*SIDE-1:SIDE] & pcut_reg) == pcut_reg) &&
                    (tile_rd == qtile_reg))
                    state_next = S_WRD;
                else
                begin
                    state_next = S_ERD;
                    cnt_next = '0;
                end
            end
            S_ERD:
            begin
                m_addr = u_reg + cnt_reg[CW-1:0];
                state_next = S_EWR;
            end
            S_EWR:
            begin
                m_we = 1'b1;
                m_addr = u_reg + cnt_reg[CW-1:0];
                m_wdata = {mask_rd[2*SIDE-1:SIDE] & ~ecut_reg, mask_rd[SIDE-1:0] & ~hcut_reg};
                cnt_next = cnt_reg + CB'(1);
                state_next = (cnt_reg + CB'(1) == w_reg) ? S_MRD : S_ERD;
            end
            S_EMIT:
                state_next = S_IDLE;
            S_EMPTY:
                state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // results are emitted one step late so final_res is known
    logic have_pend_reg;
    vsgm_pkg::result_t pend_reg;
    vsgm_pkg::result_t last_res;

    always_comb
    begin
        if (state_reg == S_EMIT)
            last_res = pend_reg;
        else
            last_res = '0;
        last_res.final_res = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLR;
            cnt_reg        <= '0;
            qcnt_reg       <= '0;
            res_strobe_reg <= 1'b0;
            have_pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            res_strobe_reg <= ((state_reg == S_MSEL) && (state_next == S_TRD) &&
                               have_pend_reg) ||
                              (state_reg == S_EMIT) || (state_reg == S_EMPTY);
            if (state_reg == S_IDLE)
                qcnt_reg <= '0;
            else if (state_reg == S_EWR && state_next == S_MRD)
                qcnt_reg <= qcnt_reg + QB'(1);
            if ((state_reg == S_WRD || state_reg == S_WCMP) && state_next == S_ERD)
                have_pend_reg <= 1'b1;
            else if ((state_reg == S_MSEL && state_next == S_TRD) ||
                     state_reg == S_EMIT || state_reg == S_EMPTY)
                have_pend_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start)
        begin
            u_reg    <= req.col[CW-1:0];
            v_reg    <= req.row[CW-1:0];
            tile_reg <= in_tile;
            draw_reg <= in_draw;
        end
        if (state_reg == S_MSEL && state_next == S_TRD)
        begin
            sv_reg   <= f_sv;
            h_reg    <= f_h;
            hcut_reg <= f_hcut;
            pcut_reg <= f_pcut;
            ecut_reg <= f_ecut;
            if (have_pend_reg)
                res_reg <= pend_reg;
        end
        if (state_reg == S_TRD)
            w_reg <= CB'(1);
        if (state_reg == S_WRD)
            qtile_reg <= (w_reg == CB'(1) && cnt_reg == CB'(1)) ? tile_rd : qtile_reg;
        if (state_reg == S_WCMP && state_next == S_WRD)
            w_reg <= w_reg + CB'(1);
        if (state_reg == S_ERD && cnt_reg == '0)
        begin
            pend_reg.quad_valid  <= 1'b1;
            pend_reg.quad_col    <= 5'(u_reg);
            pend_reg.quad_row    <= 5'(sv_reg);
            pend_reg.quad_width  <= 6'(w_reg);
            pend_reg.quad_height <= 6'(h_reg);
            pend_reg.quad_tile   <= 16'(qtile_reg);
            pend_reg.final_res   <= 1'b0;
        end
        if (state_reg == S_EMIT || state_reg == S_EMPTY)
            res_reg <= last_res;
    end

    assign busy       = (state_reg != S_IDLE);
    assign res_strobe = res_strobe_reg;
    assign res        = res_reg;
endmodule
